// ----- rtl/object_block_frame_parser_macros.svh -----
// assertion macros shared by the frame parser rtl
// depends on a clock named clk and an active-low reset named rst_n in scope
`ifndef OBJECT_BLOCK_FRAME_PARSER_MACROS_SVH
`define OBJECT_BLOCK_FRAME_PARSER_MACROS_SVH

// condition holds at every clock edge outside reset
`define OBFP_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("frame parser check failed");

// antecedent implies consequent in the next cycle
`define OBFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

// ----- rtl/obfp_pkg.sv -----
// types and constants for the object block frame parser
// no dependencies
`default_nettype none

package obfp_pkg;

  localparam logic [15:0] START_WORD         = 16'haa55;
  localparam logic [15:0] START_WORD_CC      = 16'haa56;
  localparam logic [15:0] START_WORD_SWAPPED = 16'h55aa;
  localparam logic [15:0] NO_WORD            = 16'hffff;

  localparam logic [6:0] BLOCK_CAP    = 7'd100;
  localparam logic [6:0] COUNT_MAX    = 7'd127;
  localparam logic [2:0] NORMAL_WORDS = 3'd5;
  localparam logic [2:0] CC_WORDS     = 3'd6;
  localparam int unsigned FIELD_DEPTH = 6;

  // parser phases
  localparam logic [1:0] PH_HUNT     = 2'd0;
  localparam logic [1:0] PH_CHECKSUM = 2'd1;
  localparam logic [1:0] PH_FIELDS   = 2'd2;
  localparam logic [1:0] PH_SYNC     = 2'd3;

  // result event codes
  localparam logic [1:0] EV_VALID     = 2'd0;
  localparam logic [1:0] EV_CSUM_ERR  = 2'd1;
  localparam logic [1:0] EV_FRAME_END = 2'd2;
  localparam logic [1:0] EV_NO_DATA   = 2'd3;

  // one assembled big-endian word
  typedef struct packed {
    logic        vld;
    logic [15:0] data;
  } word_t;

endpackage

`default_nettype wire

// ----- rtl/obfp_word_asm.sv -----
// byte-to-word assembler with single-byte drop for realignment
// depends on obfp_pkg
`default_nettype none

module obfp_word_asm
  import obfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       beat,
  input  wire logic [7:0] rx_byte,
  input  wire logic       drop_req,
  output word_t           word
);

  logic       half_r, half_nxt;
  logic       drop_r, drop_nxt;
  logic [7:0] high_r, high_nxt;

  assign word.vld  = beat && !drop_r && half_r;
  assign word.data = {high_r, rx_byte};

  always_comb begin
    half_nxt = half_r;
    drop_nxt = drop_r;
    high_nxt = high_r;
    if (beat) begin
      if (drop_r) begin
        drop_nxt = 1'b0;
      end else if (!half_r) begin
        high_nxt = rx_byte;
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        // skip the byte after a swapped start word
        if (drop_req) begin
          drop_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
      drop_r <= 1'b0;
      high_r <= '0;
    end else begin
      half_r <= half_nxt;
      drop_r <= drop_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/object_block_frame_parser.sv -----
// object block frame parser: a result is registered and valid in the cycle after the beat
// carrying the last byte of a word; throughput one input beat per cycle, set by the single
// register stage on the result side (input stalls only while a result waits unclaimed)
// reset is synchronous, active low: hunt phase, no pending result, max_blocks = 100
// depends on obfp_pkg, obfp_word_asm and object_block_frame_parser_macros.svh
`default_nettype none
`include "object_block_frame_parser_macros.svh"

module object_block_frame_parser
  import obfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  // byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [15:0]      out_signature,
  output logic [15:0]      out_x_pos,
  output logic [15:0]      out_y_pos,
  output logic [15:0]      out_box_width,
  output logic [15:0]      out_box_height,
  output logic [15:0]      out_angle,
  output logic             out_color_code,
  output logic [6:0]       out_block_count
);

  // configuration register
  logic [6:0]  max_blocks_r;
  logic [6:0]  limit;

  // parser state
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic        cc_r, cc_nxt;
  logic [15:0] exp_sum_r, exp_sum_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [6:0]  vcount_r, vcount_nxt;
  logic [15:0] field_words_r [FIELD_DEPTH];
  logic        fw_we;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  ev_r, ev_nxt;
  logic [15:0] sig_r, sig_nxt;
  logic [15:0] x_r, x_nxt;
  logic [15:0] y_r, y_nxt;
  logic [15:0] bw_r, bw_nxt;
  logic [15:0] bh_r, bh_nxt;
  logic [15:0] ang_r, ang_nxt;
  logic        occ_r, occ_nxt;
  logic [6:0]  cnt_r, cnt_nxt;

  logic        beat;
  logic        emit;
  logic        drop_req;
  logic        is_start;
  logic [2:0]  need;
  logic [2:0]  idx_inc;
  logic [15:0] sum_inc;
  logic [15:0] w;
  word_t       word;

  // the result register frees up in the same cycle it is drained
  assign in_ready = !out_valid_r || out_ready;
  assign beat     = in_valid && in_ready;

  obfp_word_asm u_word_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat),
    .rx_byte  (in_rx_byte),
    .drop_req (drop_req),
    .word     (word)
  );

  assign w        = word.data;
  assign is_start = (w == START_WORD) || (w == START_WORD_CC);
  assign need     = cc_r ? CC_WORDS : NORMAL_WORDS;
  assign idx_inc  = idx_r + 3'd1;
  assign sum_inc  = sum_r + w;

  // zero counts as one block, anything above the cap saturates
  always_comb begin
    if (max_blocks_r == 7'd0) begin
      limit = 7'd1;
    end else if (max_blocks_r > BLOCK_CAP) begin
      limit = BLOCK_CAP;
    end else begin
      limit = max_blocks_r;
    end
  end

  // word-level parser, one word per cycle at most
  always_comb begin
    phase_nxt   = phase_r;
    prev_nxt    = prev_r;
    cc_nxt      = cc_r;
    exp_sum_nxt = exp_sum_r;
    sum_nxt     = sum_r;
    idx_nxt     = idx_r;
    vcount_nxt  = vcount_r;
    fw_we       = 1'b0;
    drop_req    = 1'b0;
    emit        = 1'b0;
    ev_nxt      = EV_FRAME_END;
    sig_nxt     = '0;
    x_nxt       = '0;
    y_nxt       = '0;
    bw_nxt      = '0;
    bh_nxt      = '0;
    ang_nxt     = '0;
    occ_nxt     = 1'b0;
    cnt_nxt     = '0;

    if (word.vld) begin
      case (phase_r)
        PH_HUNT: begin
          if (w == 16'h0000 && prev_r == 16'h0000) begin
            // two zero words: camera has nothing to report
            prev_nxt = NO_WORD;
            emit     = 1'b1;
            ev_nxt   = EV_NO_DATA;
          end else if (prev_r == START_WORD && is_start) begin
            cc_nxt     = (w == START_WORD_CC);
            vcount_nxt = '0;
            phase_nxt  = PH_CHECKSUM;
            prev_nxt   = NO_WORD;
          end else begin
            // byte-swapped start means we are one byte off
            drop_req = (w == START_WORD_SWAPPED);
            prev_nxt = w;
          end
        end
        PH_CHECKSUM: begin
          if (is_start) begin
            // back-to-back frame start: close this one, open the next
            emit       = 1'b1;
            ev_nxt     = EV_FRAME_END;
            cnt_nxt    = vcount_r;
            vcount_nxt = '0;
            cc_nxt     = (w == START_WORD_CC);
          end else if (w == 16'h0000) begin
            emit       = 1'b1;
            ev_nxt     = EV_FRAME_END;
            cnt_nxt    = vcount_r;
            vcount_nxt = '0;
            phase_nxt  = PH_HUNT;
            prev_nxt   = NO_WORD;
          end else begin
            exp_sum_nxt = w;
            sum_nxt     = '0;
            idx_nxt     = '0;
            phase_nxt   = PH_FIELDS;
          end
        end
        PH_FIELDS: begin
          fw_we   = (idx_r < CC_WORDS);
          sum_nxt = sum_inc;
          idx_nxt = idx_inc;
          if (idx_inc == need) begin
            // last data word arrives now, straight from the assembler
            emit = 1'b1;
            if (sum_inc == exp_sum_r) begin
              ev_nxt = EV_VALID;
              if (vcount_r < COUNT_MAX) begin
                vcount_nxt = vcount_r + 7'd1;
              end
            end else begin
              ev_nxt = EV_CSUM_ERR;
            end
            sig_nxt   = field_words_r[0];
            x_nxt     = field_words_r[1];
            y_nxt     = field_words_r[2];
            bw_nxt    = field_words_r[3];
            bh_nxt    = cc_r ? field_words_r[4] : w;
            ang_nxt   = cc_r ? w : 16'h0000;
            occ_nxt   = cc_r;
            cnt_nxt   = vcount_nxt;
            idx_nxt   = '0;
            phase_nxt = PH_SYNC;
          end
        end
        PH_SYNC: begin
          if (is_start) begin
            cc_nxt = (w == START_WORD_CC);
          end
          if (is_start && vcount_r < limit) begin
            phase_nxt = PH_CHECKSUM;
          end else begin
            // anything else, or the block limit reached, closes the frame
            emit       = 1'b1;
            ev_nxt     = EV_FRAME_END;
            cnt_nxt    = vcount_r;
            vcount_nxt = '0;
            phase_nxt  = PH_HUNT;
            prev_nxt   = NO_WORD;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_blocks_r <= BLOCK_CAP;
      phase_r      <= PH_HUNT;
      prev_r       <= NO_WORD;
      cc_r         <= 1'b0;
      exp_sum_r    <= '0;
      sum_r        <= '0;
      idx_r        <= '0;
      vcount_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_blocks_r <= cfg_wr_data;
      end
      phase_r     <= phase_nxt;
      prev_r      <= prev_nxt;
      cc_r        <= cc_nxt;
      exp_sum_r   <= exp_sum_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // block words, each written once per block before it is read
  always_ff @(posedge clk) begin
    if (fw_we) begin
      field_words_r[idx_r] <= w;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (emit) begin
      ev_r  <= ev_nxt;
      sig_r <= sig_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      bw_r  <= bw_nxt;
      bh_r  <= bh_nxt;
      ang_r <= ang_nxt;
      occ_r <= occ_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = ev_r;
  assign out_signature   = sig_r;
  assign out_x_pos       = x_r;
  assign out_y_pos       = y_r;
  assign out_box_width   = bw_r;
  assign out_box_height  = bh_r;
  assign out_angle       = ang_r;
  assign out_color_code  = occ_r;
  assign out_block_count = cnt_r;

  // a result is only produced when the result register can take it
  `OBFP_ASSERT(a_emit_has_room, !emit || beat)
  // block word index stays inside the block store
  `OBFP_ASSERT(a_idx_range, phase_r != PH_FIELDS || idx_r < CC_WORDS)
  // no-data results carry no count
  `OBFP_ASSERT(a_nodata_zero, !out_valid_r || ev_r != EV_NO_DATA || cnt_r == 7'd0)
  // frame end always clears the valid block count
  `OBFP_ASSERT_NEXT(a_end_clears, emit && ev_nxt == EV_FRAME_END, vcount_r == 7'd0)

endmodule

`default_nettype wire
